// ===== rtl/pve_pkg.sv =====
// Shared types and constants for the prefix varint encoder.
package pve_pkg;

	localparam int unsigned VALUE_W        = 64;
	localparam int unsigned BYTE_W         = 8;
	localparam int unsigned MAX_DATA_BYTES = 8;
	localparam int unsigned NBYTES_W       = 4;
	localparam int unsigned QUEUE_DEPTH    = 2;

	localparam logic [BYTE_W-1:0] SHORT_MASK  = 8'h7F;
	localparam logic [BYTE_W-1:0] LONG_PREFIX = 8'hFF;
	localparam int unsigned       TOP_SHIFT   = 56;

	// One classified request: the prefix byte plus the data bytes still to send.
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [NBYTES_W-1:0] nbytes;
		logic [BYTE_W-1:0]   prefix;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

endpackage

// ===== rtl/pve_classify.sv =====
// Front end: accepts a request and works out its prefix byte and data byte count.
module pve_classify (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pve_pkg::VALUE_W-1:0]  value,
	input  pve_pkg::fifo_status_t        status,
	output logic                         push,
	output pve_pkg::entry_t              entry
);
	import pve_pkg::*;

	logic [NBYTES_W-1:0] n;
	logic [BYTE_W-1:0]   pfx;

	assign in_stall = status.full;
	assign push     = in_valid && !status.full;

	always_comb begin
		n   = NBYTES_W'(1);
		pfx = 8'h80 | value[15:8];
		// least i with value < 2^(7i+7); scan downwards so the smallest wins
		for (int i = 7; i >= 1; i--) begin
			if ((value >> (7 * i + 7)) == '0) begin
				n   = NBYTES_W'(i);
				pfx = ~(LONG_PREFIX >> i) | value[8 * i +: 8];
			end
		end
		if ((value & ~{{(VALUE_W-BYTE_W){1'b0}}, SHORT_MASK}) == '0) begin
			n   = '0;
			pfx = value[BYTE_W-1:0] & SHORT_MASK;
		end else if ((value >> TOP_SHIFT) != '0) begin
			n   = NBYTES_W'(MAX_DATA_BYTES);
			pfx = LONG_PREFIX;
		end
	end

	assign entry.value  = value;
	assign entry.nbytes = n;
	assign entry.prefix = pfx;

endmodule

// ===== rtl/pve_fifo.sv =====
// Short queue between the classifier and the byte serialiser.
module pve_fifo #(
	parameter int unsigned DEPTH = pve_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  pve_pkg::entry_t        wdata,
	input  logic                   pop,
	output pve_pkg::entry_t        rdata,
	output pve_pkg::fifo_status_t  status
);
	import pve_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t            slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;

	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == CNT_W'(DEPTH));
	assign rdata        = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full || pop)
		else $error("queue written while full");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("queue fill count out of range");

endmodule

// ===== rtl/pve_serialiser.sv =====
// Back end: sends the prefix byte and then the data bytes, low byte first.
module pve_serialiser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pve_pkg::entry_t              head,
	input  pve_pkg::fifo_status_t        status,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pve_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last
);
	import pve_pkg::*;

	logic [VALUE_W-1:0]  cur_q;
	logic [NBYTES_W-1:0] rem_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                last_q;
	logic                advance;

	assign advance   = !out_valid_q || !out_stall;
	assign pop       = advance && (rem_q == '0) && !status.empty;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (rem_q != '0) begin
				out_byte_q <= cur_q[BYTE_W-1:0];
				last_q     <= (rem_q == NBYTES_W'(1));
				cur_q      <= cur_q >> BYTE_W;
			end else if (!status.empty) begin
				out_byte_q <= head.prefix;
				last_q     <= (head.nbytes == '0);
				cur_q      <= head.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (rem_q != '0) begin
				rem_q       <= rem_q - 1'b1;
				out_valid_q <= 1'b1;
			end else if (!status.empty) begin
				rem_q       <= head.nbytes;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= NBYTES_W'(MAX_DATA_BYTES))
		else $error("data byte count out of range");

	a_not_last_midway: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> out_valid_q && !last_q)
		else $error("last flagged while data bytes remain");

	a_rem_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && rem_q != '0) |=> rem_q == $past(rem_q) - 1'b1)
		else $error("data byte count skipped");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rem_q == '0 && !status.empty)
		else $error("queue popped mid-number");

endmodule

// ===== rtl/prefix_varint_encoder.sv =====
// Top level of the prefix varint encoder: classifier, queue and byte serialiser.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------
//  input   | in        | in_valid / in_stall | value[63:0]
//  output  | out       | out_valid/out_stall | out_byte[7:0], last
//
// Each request yields 1 to 9 output bytes, one per cycle while out_stall is low;
// the byte-wide output register sets the rate.
// Classification is done in the accepting cycle; a new request can be taken
// every cycle while the queue (QUEUE_DEPTH entries) has room.
// Consecutive numbers leave the serialiser without a gap cycle between them.
// Reset clears queue pointers, the remaining-byte count and out_valid.
// A stall on the output holds the output register; the queue absorbs input
// until full, then in_stall rises.
module prefix_varint_encoder #(
	parameter int unsigned QUEUE_DEPTH = pve_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [pve_pkg::VALUE_W-1:0]  value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pve_pkg::BYTE_W-1:0]   out_byte,
	output logic                         last
);
	import pve_pkg::*;

	entry_t       push_entry;
	entry_t       head_entry;
	fifo_status_t q_status;
	logic         push;
	logic         pop;

	// front: accept and classify
	pve_classify u_classify (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.status   (q_status),
		.push     (push),
		.entry    (push_entry)
	);

	// decoupling queue
	pve_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_entry),
		.pop    (pop),
		.rdata  (head_entry),
		.status (q_status)
	);

	// back: emit bytes
	pve_serialiser u_serialiser (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_entry),
		.status    (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
